@@ src/ktd_pkg.sv @@
// ktd_pkg: shared widths, payload structs and the token that travels the cell row
// used by ktd_cell and kendall_tau_distance; no dependencies
package ktd_pkg;

    localparam int MAX_LEN  = 16;
    localparam int VAL_W    = 5;
    localparam int CFG_W    = 5;
    localparam int DIST_W   = 7;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int POS_W    = $clog2(MAX_LEN + 1);
    localparam int CNT_W    = $clog2(MAX_LEN);
    localparam int ACC_W    = $clog2(MAX_LEN * (MAX_LEN - 1) / 2 + 1);
    localparam int CMP_W    = (VAL_W > POS_W) ? VAL_W : POS_W;
    localparam int SAT_W    = (ACC_W > DIST_W) ? ACC_W : DIST_W;
    localparam int DRAIN_W  = $clog2(MAX_LEN + 3);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic [VAL_W-1:0] candidate_value;
        logic [VAL_W-1:0] observed_value;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              bad_value;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic             fresh;
        logic [POS_W-1:0] value;
        logic [CNT_W-1:0] count;
    } token_t;

    function automatic logic [POS_W-1:0] eff_length(input logic [CFG_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v == '0)
            r = POS_W'(1);
        else if (CMP_W'(v) > CMP_W'(MAX_LEN))
            r = POS_W'(MAX_LEN);
        else
            r = POS_W'(v);
        return r;
    endfunction

endpackage

@@ src/ktd_ram.sv @@
// ktd_ram: generic single-write, single-read memory with registered read data
// no dependencies
module ktd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ktd_cell.sv @@
// ktd_cell: one cell of the inversion row; keeps one position and counts later smaller ones
// depends on ktd_pkg
module ktd_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  ktd_pkg::token_t tok_in,
    output ktd_pkg::token_t tok_out
);

    import ktd_pkg::*;

    logic             held_valid_reg;
    logic             held_valid_next;
    logic [POS_W-1:0] held_value_reg;
    logic [POS_W-1:0] held_value_next;
    token_t           tok_reg;
    token_t           tok_next;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        tok_next        = tok_in;
        if (clear)
        begin
            held_valid_next = 1'b0;
        end
        else if (tok_in.valid)
        begin
            if (!held_valid_reg)
            begin
                if (tok_in.fresh)
                begin
                    held_valid_next = 1'b1;
                    held_value_next = tok_in.value;
                    tok_next.fresh  = 1'b0;
                end
            end
            else if (held_value_reg > tok_in.value)
            begin
                tok_next.count = tok_in.count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            tok_reg        <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            tok_reg        <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_value_reg <= held_value_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ src/kendall_tau_distance.sv @@
// kendall_tau_distance: top level; loads two permutations and counts discordant pairs
// depends on ktd_pkg, ktd_ram, ktd_cell
//
// Items are taken one per cycle while busy is low. After the last position of a
// permutation the block raises busy, streams the mapped positions into a row of
// MAX_LEN cells and sums the counts that leave the row; busy stays high while the
// perm_length positions are fed in and travel through the cell row. The result
// then shows for one cycle with done high; there is no way to hold it off, so it
// must be taken in that cycle. A permutation with a value outside 1..perm_length
// gives its result (distance zero, bad_value set) in the cycle after its last
// item, without going busy. Writes to perm_length are taken while busy is low and
// restart the permutation.
module kendall_tau_distance (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  ktd_pkg::item_t           item,
    output logic                     done,
    output ktd_pkg::result_t         result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ktd_pkg::CFG_W-1:0] cfg_data
);

    import ktd_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FEED,
        ST_DRAIN
    } state_t;

    localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(MAX_LEN + 2);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               err_reg, err_next;
    logic [IDX_W-1:0]   rd_reg, rd_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    logic               accept;
    logic               cfg_write;
    logic               cand_bad;
    logic               obs_bad;
    logic               err_now;
    logic [POS_W-1:0]   pos_plus;
    logic               last_item;
    logic               last_issue;
    logic               clear_row;
    logic [VAL_W-1:0]   cand_rdata;
    logic [POS_W-1:0]   inv_rdata;
    logic [IDX_W-1:0]   inv_raddr;
    logic [IDX_W-1:0]   inv_waddr;
    logic               sat;
    token_t             tok [MAX_LEN+1];

    assign accept     = start && !busy;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign cand_bad   = (item.candidate_value == '0)
                     || (CMP_W'(item.candidate_value) > CMP_W'(len_reg));
    assign obs_bad    = (item.observed_value == '0)
                     || (CMP_W'(item.observed_value) > CMP_W'(len_reg));
    assign err_now    = err_reg || cand_bad || obs_bad;
    assign pos_plus   = POS_W'(pos_reg) + POS_W'(1);
    assign last_item  = (pos_plus == len_reg);
    assign last_issue = ((POS_W'(rd_reg) + POS_W'(1)) == len_reg);
    assign clear_row  = accept && last_item && !err_now;
    assign inv_waddr  = IDX_W'(item.observed_value - VAL_W'(1));
    assign inv_raddr  = IDX_W'(cand_rdata - VAL_W'(1));
    assign sat        = SAT_W'(acc_reg) > SAT_W'(DIST_MAX);

    ktd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_cand_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (pos_reg),
        .wdata (item.candidate_value),
        .raddr (rd_reg),
        .rdata (cand_rdata)
    );

    ktd_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_LEN)
    ) u_inv_ram (
        .clk   (clk),
        .we    (accept && !obs_bad),
        .waddr (inv_waddr),
        .wdata (pos_plus),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    assign tok[0] = '{
        valid: v2_reg && (inv_rdata != '0),
        fresh: 1'b1,
        value: inv_rdata,
        count: '0
    };

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_row
        ktd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear_row),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        rd_next     = rd_reg;
        v1_next     = 1'b0;
        v2_next     = v1_reg;
        acc_next    = acc_reg;
        drain_next  = drain_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (tok[MAX_LEN].valid)
        begin
            acc_next = acc_reg + ACC_W'(tok[MAX_LEN].count);
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (last_item)
                    begin
                        pos_next = '0;
                        err_next = 1'b0;
                        if (err_now)
                        begin
                            done_next            = 1'b1;
                            result_next.distance = '0;
                            result_next.bad_value = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_FEED;
                            rd_next    = '0;
                            acc_next   = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                        err_next = err_now;
                    end
                end
                if (cfg_write)
                begin
                    len_next = eff_length(cfg_data);
                    pos_next = '0;
                    err_next = 1'b0;
                end
            end
            ST_FEED:
            begin
                v1_next = 1'b1;
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
                else
                begin
                    rd_next = rd_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next            = ST_LOAD;
                    done_next             = 1'b1;
                    result_next.distance  = sat ? DIST_MAX : DIST_W'(acc_reg);
                    result_next.bad_value = 1'b0;
                end
                else
                begin
                    drain_next = drain_reg + DRAIN_W'(1);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            len_reg    <= POS_W'(MAX_LEN);
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            rd_reg     <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            acc_reg    <= '0;
            drain_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            err_reg    <= err_next;
            rd_reg     <= rd_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            acc_reg    <= acc_next;
            drain_reg  <= drain_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = (state_reg == ST_LOAD);
    assign done      = done_reg;
    assign result    = result_reg;

endmodule
